[hw/rtl/sha1_stream_hasher_macros.svh]
// Assertion macros shared by the hasher RTL files.
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, quiet while reset is asserted.
`define SHA1S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define SHA1S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA1S_ASSERT(label, prop, msg)
`define SHA1S_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/sha1s_pkg.sv]
// Types, constants and state codes of the SHA-1 stream hasher.
package sha1s_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;
  typedef word_t [4:0] hash_t;

  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_DIGEST  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  localparam int unsigned ROUND_W = 7;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [ROUND_W-1:0] ROUND_B1 = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_B2 = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_B3 = 7'd60;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam hash_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                              32'hefcdab89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // byte position from which the length no longer fits in the block (448 bits)
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd4;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  typedef struct packed {
    logic start;
    logic keep_cv;
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  typedef enum logic [1:0] {
    CMP_IDLE,
    CMP_RUN,
    CMP_ADD,
    CMP_DONE
  } cmp_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_GO,
    ST_ABS_WAIT,
    ST_DIG_GO,
    ST_DIG_WAIT,
    ST_DIG_GO2,
    ST_DIG_WAIT2,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    SRC_BLOCK,
    SRC_PAD1,
    SRC_PAD2
  } blk_src_t;

endpackage

[hw/rtl/sha1s_if.sv]
// Valid/ready channel interfaces for command words and digest words.
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

[hw/rtl/sha1s_round.sv]
// One SHA-1 round: mixing function, constant select and the five-term add.
module sha1s_round (
  input  logic [sha1s_pkg::ROUND_W-1:0] round,
  input  sha1s_pkg::hash_t              st_in,
  input  sha1s_pkg::word_t              wt,
  output sha1s_pkg::hash_t              st_out
);
  import sha1s_pkg::*;

  word_t a, b, c, d, e;
  word_t f, k, tmp;

  assign a = st_in[0];
  assign b = st_in[1];
  assign c = st_in[2];
  assign d = st_in[3];
  assign e = st_in[4];

  always_comb begin
    if (round < ROUND_B1) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < ROUND_B2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < ROUND_B3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + wt;

  assign st_out[0] = tmp;
  assign st_out[1] = a;
  assign st_out[2] = {b[1:0], b[31:2]};
  assign st_out[3] = c;
  assign st_out[4] = d;

endmodule

[hw/rtl/sha1s_compress.sv]
// Compression sequencer: 16-word schedule window, round counter, chaining add.
module sha1s_compress (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1s_pkg::cmp_ctrl_t ctrl,
  input  sha1s_pkg::blk_t      blk,
  input  sha1s_pkg::hash_t     h_in,
  output sha1s_pkg::cmp_stat_t stat,
  output sha1s_pkg::hash_t     cv
);
  import sha1s_pkg::*;
  `include "sha1_stream_hasher_macros.svh"

  cmp_state_t state_r, state_nxt;
  logic [ROUND_W-1:0] t_r;
  blk_t  w_r;
  hash_t st_r, cv_r, st_round, base;
  word_t w_new;
  logic  load, run, add;

  sha1s_round u_round (
    .round (t_r),
    .st_in (st_r),
    .wt    (w_r[0]),
    .st_out(st_round)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CMP_IDLE: if (ctrl.start) state_nxt = CMP_RUN;
      CMP_RUN:  if (t_r == LAST_ROUND) state_nxt = CMP_ADD;
      CMP_ADD:  state_nxt = CMP_DONE;
      CMP_DONE: state_nxt = CMP_IDLE;
      default:  state_nxt = CMP_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    run  = 1'b0;
    add  = 1'b0;
    stat = '0;
    case (state_r)
      CMP_IDLE: load = ctrl.start;
      CMP_RUN: begin
        run       = 1'b1;
        stat.busy = 1'b1;
      end
      CMP_ADD: begin
        add       = 1'b1;
        stat.busy = 1'b1;
      end
      CMP_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  assign base = ctrl.keep_cv ? cv_r : h_in;
  // window holds w[t] .. w[t+15]; the new word is w[t+16]
  assign w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CMP_IDLE;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        t_r <= '0;
      end else if (run) begin
        t_r <= t_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w_r  <= blk;
      st_r <= base;
      cv_r <= base;
    end else if (run) begin
      st_r <= st_round;
      w_r  <= {{w_new[30:0], w_new[31]}, w_r[15:1]};
    end else if (add) begin
      for (int i = 0; i < 5; i++) begin
        cv_r[i] <= cv_r[i] + st_r[i];
      end
    end
  end

  assign cv = cv_r;

  `SHA1S_ASSERT(a_start_idle, ctrl.start |-> (state_r == CMP_IDLE), "start while busy")
  `SHA1S_ASSERT(a_run_len, (state_r == CMP_RUN) && (t_r == LAST_ROUND) |=> add, "round count")
  `SHA1S_ASSERT(a_done_once, stat.done |=> !stat.done && !stat.busy, "done not single")

endmodule

[hw/rtl/sha1_stream_hasher.sv]
// Top level of the SHA-1 stream hasher: command decode, block buffer, output.
//
// Input channel in_chan carries one command word per handshake: absorb a
// message byte, emit the digest of what was absorbed so far, or restart.
// Absorb stores the byte and stays idle, except the byte that fills a 64-byte
// block, after which the block is compressed: a load, 80 rounds on the single
// round unit, a chaining add and a done state; no further command word is
// taken until the compression is through.
// Digest pads a copy of the block and compresses it (and a second block when
// the length spills over), then offers the five digest words on
// out_chan, word 0 first, last set on word 4. The running hash is kept, so
// absorbing may go on afterwards. A stalled receiver holds the current digest
// word; no command is taken until all five have been taken.
// Restart and an unused command return nothing and leave the hasher idle.
// Reset loads the initial hash values and clears the bit count; the block
// buffer is not cleared, since bytes past the fill point are always padded.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  sha1s_in_if.sink    in_chan,
  sha1s_out_if.source out_chan
);
  import sha1s_pkg::*;
  `include "sha1_stream_hasher_macros.svh"

  top_state_t state_r, state_nxt;
  hash_t      h_r, cv;
  blk_t       block_r, pad1, pad2, cmp_blk;
  logic [63:0] bit_count_r;
  logic [2:0]  idx_r;
  logic [5:0]  pos;
  logic        in_acc, out_acc, two_blk;
  blk_src_t    src;
  cmp_ctrl_t   cmp_ctrl;
  cmp_stat_t   cmp_stat;

  assign pos     = bit_count_r[8:3];
  assign two_blk = (pos >= LEN_POS);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  sha1s_compress u_compress (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (cmp_ctrl),
    .blk  (cmp_blk),
    .h_in (h_r),
    .stat (cmp_stat),
    .cv   (cv)
  );

  // padded copy of the block: keep bytes below pos, mark pos, zero the rest, length in words 14-15 if it fits
  always_comb begin
    pad1 = block_r;
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(w * 4 + b) == pos) begin
          pad1[w][8*(3-b) +: 8] = PAD_BYTE;
        end else if (6'(w * 4 + b) > pos) begin
          pad1[w][8*(3-b) +: 8] = 8'h00;
        end
      end
    end
    if (!two_blk) begin
      pad1[14] = bit_count_r[63:32];
      pad1[15] = bit_count_r[31:0];
    end
    pad2     = '0;
    pad2[14] = bit_count_r[63:32];
    pad2[15] = bit_count_r[31:0];
  end

  always_comb begin
    case (src)
      SRC_BLOCK: cmp_blk = block_r;
      SRC_PAD1:  cmp_blk = pad1;
      SRC_PAD2:  cmp_blk = pad2;
      default:   cmp_blk = block_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.cmd == CMD_ABSORB && pos == LAST_POS) begin
            state_nxt = ST_ABS_GO;
          end else if (in_chan.cmd == CMD_DIGEST) begin
            state_nxt = ST_DIG_GO;
          end
        end
      end
      ST_ABS_GO:    state_nxt = ST_ABS_WAIT;
      ST_ABS_WAIT:  if (cmp_stat.done) state_nxt = ST_IDLE;
      ST_DIG_GO:    state_nxt = ST_DIG_WAIT;
      ST_DIG_WAIT:  if (cmp_stat.done) state_nxt = two_blk ? ST_DIG_GO2 : ST_OUT;
      ST_DIG_GO2:   state_nxt = ST_DIG_WAIT2;
      ST_DIG_WAIT2: if (cmp_stat.done) state_nxt = ST_OUT;
      ST_OUT:       if (out_acc && idx_r == LAST_IDX) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready    = 1'b0;
    out_chan.valid   = 1'b0;
    cmp_ctrl         = '0;
    src              = SRC_BLOCK;
    case (state_r)
      ST_IDLE:    in_chan.ready = 1'b1;
      ST_ABS_GO:  cmp_ctrl.start = 1'b1;
      ST_DIG_GO: begin
        cmp_ctrl.start = 1'b1;
        src            = SRC_PAD1;
      end
      ST_DIG_GO2: begin
        cmp_ctrl.start   = 1'b1;
        cmp_ctrl.keep_cv = 1'b1;
        src              = SRC_PAD2;
      end
      ST_OUT:     out_chan.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_chan.digest_word = cv[idx_r];
  assign out_chan.word_index  = idx_r;
  assign out_chan.last        = (idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= H_INIT;
      bit_count_r <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_chan.cmd == CMD_ABSORB) begin
        bit_count_r <= bit_count_r + BYTE_BITS;
      end else if (in_acc && in_chan.cmd == CMD_RESTART) begin
        bit_count_r <= '0;
        h_r         <= H_INIT;
      end
      // commit the chaining value of a full block
      if (state_r == ST_ABS_WAIT && cmp_stat.done) begin
        h_r <= cv;
      end
      if (out_acc) begin
        idx_r <= (idx_r == LAST_IDX) ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.cmd == CMD_ABSORB) begin
      block_r[pos[5:2]][8*(3-pos[1:0]) +: 8] <= in_chan.data_byte;
    end
  end

  `SHA1S_ASSERT_ALWAYS(a_no_overlap, !(in_chan.ready && out_chan.valid), "in and out both open")
  `SHA1S_ASSERT(a_dig_start, in_acc && in_chan.cmd == CMD_DIGEST |=> cmp_ctrl.start, "no start")
  `SHA1S_ASSERT(a_last_idle, out_acc && out_chan.last |=> in_chan.ready, "not idle after last")
  `SHA1S_ASSERT(a_count, in_acc && in_chan.cmd == CMD_ABSORB |=>
                bit_count_r == $past(bit_count_r) + BYTE_BITS, "bit count step")

endmodule
